FILE: sv/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and codes for the circular list engine: request opcodes,
// result status codes, controller states and the cell command bundle.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_DROP_HEAD  = 3'd2,
    OP_DROP_TAIL  = 3'd3,
    OP_DROP_AFTER = 3'd4,
    OP_LIST       = 3'd5
  } cle_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_LISTED   = 3'd4
  } cle_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DROP,
    S_REWIND,
    S_LIST
  } cle_state_t;

  // Commands broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_PREPEND,
    CMD_ROTATE,
    CMD_DROP
  } cle_cmd_t;

  typedef struct packed {
    cle_cmd_t                 cmd;
    logic signed [WORD_W-1:0] value;
  } cle_ctrl_t;

endpackage

FILE: sv/circular_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_engine
// Append, prepend, remove head/tail and empty cases put their one
//   result in the output register in the cycle after the request is accepted.
// Remove-after turns the row one cell per cycle while searching
//   and rewinding, and waits for a free output register to give its result.
// List gives one result per cycle while the output is taken.
// One request at a time; the next is taken once the walk is done.
// Reset clears the element count (empty list); cell contents stay undefined.
// ----------------------------------------------------------------------------
module circular_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [cle_pkg::OP_W-1:0]           op,
  input  logic signed [cle_pkg::WORD_W-1:0]  value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [cle_pkg::WORD_W-1:0]  item,
  output logic [cle_pkg::ST_W-1:0]           status,
  output logic                               last
);
  import cle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cle_state_t               state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            step, step_next;
  logic [CW-1:0]            count_m1;
  logic signed [WORD_W-1:0] key;
  cle_ctrl_t                ctrl;

  logic                     res_load;
  logic signed [WORD_W-1:0] item_next;
  cle_status_t              status_next;
  logic                     last_next;

  logic                     out_free;
  logic                     req_fire;
  logic                     match;
  logic signed [WORD_W-1:0] cell_data [DEPTH];

  assign out_free = !res_valid || res_ready;
  assign req_fire = req_valid && req_ready;
  assign count_m1 = count - 1'b1;
  assign match    = (cell_data[0] == key);

  // Row of cells: cell i reads i-1 on prepend, i+1 on rotate and drop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_w = cell_data[0];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    cle_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (cell_data[0]),
      .word       (cell_data[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire && count != '0) begin
          if (op == OP_DROP_AFTER) state_next = S_SEARCH;
          else if (op == OP_LIST) state_next = S_LIST;
        end
      end
      S_SEARCH: begin
        if (match) state_next = S_DROP;
        else if (step == count_m1 && out_free) state_next = S_IDLE;
      end
      S_DROP: begin
        if (out_free) state_next = (count_m1 == '0) ? S_IDLE : S_REWIND;
      end
      S_REWIND: begin
        if (step == CW'(1)) state_next = S_IDLE;
      end
      S_LIST: begin
        if (out_free && step == count_m1) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    req_ready   = (state == S_IDLE) && out_free;
    ctrl.cmd    = CMD_HOLD;
    ctrl.value  = value;
    count_next  = count;
    step_next   = step;
    res_load    = 1'b0;
    item_next   = '0;
    status_next = ST_OK;
    last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          step_next = '0;
          case (op)
            OP_APPEND, OP_PREPEND: begin
              res_load = 1'b1;
              if (count == FULL_COUNT) begin
                status_next = ST_FULL;
              end else begin
                ctrl.cmd   = (op == OP_APPEND) ? CMD_APPEND : CMD_PREPEND;
                count_next = count + 1'b1;
              end
            end
            OP_DROP_HEAD, OP_DROP_TAIL: begin
              res_load = 1'b1;
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                if (op == OP_DROP_HEAD) ctrl.cmd = CMD_ROTATE;
                count_next = count_m1;
              end
            end
            OP_DROP_AFTER, OP_LIST: begin
              if (count == '0) begin
                res_load    = 1'b1;
                status_next = ST_EMPTY;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_SEARCH: begin
        // step counts the rotations so far; on a match it holds the position
        if (!match) begin
          if (step == count_m1) begin
            if (out_free) begin
              ctrl.cmd    = CMD_ROTATE;
              res_load    = 1'b1;
              status_next = ST_NOTFOUND;
            end
          end else begin
            ctrl.cmd  = CMD_ROTATE;
            step_next = step + 1'b1;
          end
        end
      end
      S_DROP: begin
        if (out_free) begin
          ctrl.cmd   = CMD_DROP;
          count_next = count_m1;
          res_load   = 1'b1;
          // matched word sits in cell zero; turn the row until the head leads
          step_next  = (step == count_m1) ? CW'(1) : count_m1 - step;
        end
      end
      S_REWIND: begin
        ctrl.cmd  = CMD_ROTATE;
        step_next = step - 1'b1;
      end
      S_LIST: begin
        if (out_free) begin
          ctrl.cmd    = CMD_ROTATE;
          res_load    = 1'b1;
          item_next   = cell_data[0];
          status_next = ST_LISTED;
          last_next   = (step == count_m1);
          step_next   = step + 1'b1;
        end
      end
      default: ctrl.cmd = CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) key <= value;
    if (res_load) begin
      item   <= item_next;
      status <= status_next;
      last   <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("element count beyond depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (req_fire && count == FULL_COUNT && (op == OP_APPEND || op == OP_PREPEND))
      |=> (count == FULL_COUNT && status == ST_FULL))
    else $error("insert into full list changed it");

  a_drop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP && out_free) |=> (count == $past(count_m1)))
    else $error("remove after did not shrink the list by one");

  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && res_load && last_next) |=> (state == S_IDLE && res_valid))
    else $error("list walk did not finish on its last element");
`endif

endmodule

FILE: sv/cle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_cell
// One storage cell of the list row. Holds one word and, on each command,
// keeps it, loads the request word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module cle_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                                clk,
  input  cle_pkg::cle_ctrl_t                  ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]          count,
  input  logic signed [cle_pkg::WORD_W-1:0]   left_word,
  input  logic signed [cle_pkg::WORD_W-1:0]   right_word,
  input  logic signed [cle_pkg::WORD_W-1:0]   head_word,
  output logic signed [cle_pkg::WORD_W-1:0]   word
);
  import cle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [CW-1:0]             count_m1;
  logic signed [WORD_W-1:0]  word_next;

  assign count_m1 = count - 1'b1;

  always_comb begin
    word_next = word;
    case (ctrl.cmd)
      CMD_APPEND: begin
        if (IDX_C == count) word_next = ctrl.value;
      end
      CMD_PREPEND: begin
        word_next = left_word;
      end
      CMD_ROTATE: begin
        // last live cell wraps around to the head
        if (IDX_C == count_m1) word_next = head_word;
        else if (IDX_C < count_m1) word_next = right_word;
      end
      CMD_DROP: begin
        // close the gap left by the word in cell one
        if (IDX_C != '0 && IDX_C < count_m1) word_next = right_word;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule
